// ===== hdl/caliper_frame_decoder_unit_macros.svh =====
// assertion helpers shared by the decoder modules
`ifndef CALIPER_FRAME_DECODER_UNIT_MACROS_SVH
`define CALIPER_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CFD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("caliper decoder assertion failed");

`define CFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("caliper decoder assertion failed");

`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("caliper decoder assertion failed");

`else

`define CFD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/cfd_pkg.sv =====
package cfd_pkg;

    typedef enum logic [1:0]
    {
        REG_PROTOCOL_MODE,
        REG_CLOCK_ACTIVE_LEVEL,
        REG_DATA_INVERT,
        REG_UNIT_INCH
    } cfg_reg_t;

    typedef struct packed
    {
        logic protocol_mode;
        logic clock_active_level;
        logic data_invert;
        logic unit_inch;
    } cfg_t;

    typedef struct packed
    {
        logic [23:0] frame;
        logic        data_invert;
        logic        unit_inch;
    } frame_item_t;

    localparam logic [23:0] MASK_BIN6  = 24'hffffff;
    localparam logic [23:0] MASK_24BIT = 24'hfffff8;

    localparam logic [7:0] GAP_BIN6  = 8'd8;
    localparam logic [7:0] GAP_24BIT = 8'd25;

    localparam logic [5:0] FIRST_BIT_BIN6  = 6'd0;
    localparam logic [5:0] FIRST_BIT_24BIT = 6'd24;
    localparam logic [5:0] LAST_BIT_BIN6   = 6'd23;
    localparam logic [5:0] LAST_BIT_24BIT  = 6'd47;
    localparam logic [5:0] FRAME_BITS      = 6'd24;

    localparam int DIVIDEND_W  = 29;
    localparam int RECIP_W     = 28;
    localparam int PRODUCT_W   = 57;
    localparam int RECIP_SHIFT = 34;
    localparam int QUOT_W      = 21;

    // floor(2**34 / divisor), quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP_635 = 28'd27054912;
    localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798691;
    localparam logic [9:0]         DIV_635   = 10'd635;
    localparam logic [9:0]         DIV_100   = 10'd100;

    localparam logic [DIVIDEND_W-1:0] MM_TO_INCH_MUL = 29'd500;
    localparam logic [DIVIDEND_W-1:0] MM_TO_INCH_ADD = 29'd63;
    localparam logic [DIVIDEND_W-1:0] INCH_TO_MM_MUL = 29'd127;
    localparam logic [DIVIDEND_W-1:0] INCH_TO_MM_ADD = 29'd50;
    localparam logic [22:0]           INCH_STEP      = 23'd5;

    localparam logic [2:0] DECIMALS_MM   = 3'd2;
    localparam logic [2:0] DECIMALS_INCH = 3'd4;

    localparam logic signed [23:0] READING_LIMIT = 24'sd5242875;

endpackage

// ===== hdl/cfd_frame.sv =====
`include "caliper_frame_decoder_unit_macros.svh"

module cfd_frame
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfd_pkg::cfg_t        cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    output logic                 frm_valid,
    input  logic                 frm_ready,
    output cfd_pkg::frame_item_t frm_item
);
    import cfd_pkg::*;

    logic        in_valid_reg;
    logic        in_clock_reg;
    logic        in_data_reg;
    logic [7:0]  in_ticks_reg;

    logic        frame_active_reg;
    logic        frame_active_next;
    logic [5:0]  bit_count_reg;
    logic [5:0]  bit_count_next;
    logic [23:0] shift_word_reg;
    logic [23:0] shift_word_next;
    logic [23:0] last_frame_reg;
    logic [23:0] last_frame_next;
    logic        first_pending_reg;
    logic        first_pending_next;

    logic        frm_valid_reg;
    frame_item_t frm_item_reg;

    logic        process;
    logic [7:0]  gap;
    logic [5:0]  first_bit;
    logic [5:0]  last_bit;
    logic [23:0] mask;
    logic        arm;
    logic        active;
    logic        take;
    logic        done;
    logic        emit;
    logic [5:0]  count_a;
    logic [5:0]  count_inc;
    logic [5:0]  pos;
    logic [23:0] word_a;
    logic [23:0] word_take;
    logic [23:0] frame_word;
    logic [23:0] last_masked;

    assign process   = in_valid_reg && (!frm_valid_reg || frm_ready);
    assign s_tready  = !in_valid_reg || process;
    assign frm_valid = frm_valid_reg;
    assign frm_item  = frm_item_reg;

    always_comb
    begin
        gap       = cfg.protocol_mode ? GAP_24BIT : GAP_BIN6;
        first_bit = cfg.protocol_mode ? FIRST_BIT_24BIT : FIRST_BIT_BIN6;
        last_bit  = cfg.protocol_mode ? LAST_BIT_24BIT : LAST_BIT_BIN6;
        mask      = cfg.protocol_mode ? MASK_24BIT : MASK_BIN6;

        // gap test comes first, so the arming sample can carry bit zero
        arm     = !frame_active_reg && (in_ticks_reg > gap);
        active  = frame_active_reg || arm;
        count_a = arm ? 6'd0 : bit_count_reg;
        word_a  = arm ? 24'd0 : shift_word_reg;
        take    = active && (in_clock_reg == cfg.clock_active_level);

        pos       = count_a - first_bit;
        word_take = word_a;
        if ((count_a >= first_bit) && (pos < FRAME_BITS) && in_data_reg)
        begin
            word_take = word_a | (24'd1 << pos[4:0]);
        end

        count_inc   = count_a + 6'd1;
        done        = take && (count_inc > last_bit);
        frame_word  = word_take & mask;
        last_masked = last_frame_reg & mask;
        emit        = done && ((last_masked != frame_word) || first_pending_reg);

        frame_active_next  = done ? 1'b0 : active;
        bit_count_next     = done ? 6'd0 : (take ? count_inc : count_a);
        shift_word_next    = done ? 24'd0 : (take ? word_take : word_a);
        last_frame_next    = done ? (emit ? frame_word : last_masked) : last_frame_reg;
        first_pending_next = first_pending_reg && !emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            frame_active_reg  <= 1'b0;
            bit_count_reg     <= 6'd0;
            shift_word_reg    <= 24'd0;
            last_frame_reg    <= 24'd0;
            first_pending_reg <= 1'b1;
            frm_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (process)
            begin
                frame_active_reg  <= frame_active_next;
                bit_count_reg     <= bit_count_next;
                shift_word_reg    <= shift_word_next;
                last_frame_reg    <= last_frame_next;
                first_pending_reg <= first_pending_next;
            end
            if (!frm_valid_reg || frm_ready)
            begin
                frm_valid_reg <= process && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_clock_reg <= s_tdata[0];
            in_data_reg  <= s_tdata[1];
            in_ticks_reg <= s_tdata[9:2];
        end
        if (process && emit)
        begin
            frm_item_reg.frame       <= frame_word;
            frm_item_reg.data_invert <= cfg.data_invert;
            frm_item_reg.unit_inch   <= cfg.unit_inch;
        end
    end

    `CFD_ASSERT_ALWAYS(a_count_range, clk, rst_n, bit_count_reg <= LAST_BIT_24BIT)
    `CFD_ASSERT_IMPL(a_idle_clean, clk, rst_n, !frame_active_reg, (bit_count_reg == 6'd0) && (shift_word_reg == 24'd0))
    `CFD_ASSERT_NEXT(a_first_sticky, clk, rst_n, !first_pending_reg, !first_pending_reg)

endmodule

// ===== hdl/cfd_convert.sv =====
`include "caliper_frame_decoder_unit_macros.svh"

module cfd_convert
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cfd_pkg::frame_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [23:0]   reading,
    output logic [2:0]           decimals
);
    import cfd_pkg::*;

    logic                  en_a;
    logic                  en_b;
    logic                  en_c;

    // stage a: unpack and dividend
    logic [23:0]           v_full;
    logic [19:0]           v;
    logic                  sel635;
    logic                  use_div;
    logic [DIVIDEND_W-1:0] dividend;
    logic [22:0]           direct;

    logic                  a_valid_reg;
    logic [DIVIDEND_W-1:0] a_dividend_reg;
    logic                  a_sel635_reg;
    logic                  a_use_div_reg;
    logic [22:0]           a_direct_reg;
    logic                  a_neg_reg;
    logic [2:0]            a_decimals_reg;

    // stage b: reciprocal multiply
    logic [PRODUCT_W-1:0]  product;

    logic                  b_valid_reg;
    logic [QUOT_W-1:0]     b_quot_reg;
    logic [DIVIDEND_W-1:0] b_dividend_reg;
    logic                  b_sel635_reg;
    logic                  b_use_div_reg;
    logic [22:0]           b_direct_reg;
    logic                  b_neg_reg;
    logic [2:0]            b_decimals_reg;

    // stage c: correction, scaling and sign
    logic [9:0]            divisor;
    logic [10:0]           divisor_x2;
    logic [30:0]           quot_times_div;
    logic [DIVIDEND_W-1:0] remainder;
    logic [QUOT_W-1:0]     quot;
    logic [22:0]           mag;
    logic [23:0]           mag_ext;

    logic                  c_valid_reg;
    logic signed [23:0]    reading_reg;
    logic [2:0]            decimals_reg;

    assign en_c      = !c_valid_reg || out_ready;
    assign en_b      = !b_valid_reg || en_c;
    assign en_a      = !a_valid_reg || en_b;
    assign in_ready  = en_a;
    assign out_valid = c_valid_reg;
    assign reading   = reading_reg;
    assign decimals  = decimals_reg;

    always_comb
    begin
        v_full  = in_item.frame ^ {24{in_item.data_invert}};
        v       = v_full[19:0];
        use_div = v_full[23] != in_item.unit_inch;
        sel635  = in_item.unit_inch;
        if (sel635)
        begin
            dividend = ({9'd0, v} * MM_TO_INCH_MUL) + MM_TO_INCH_ADD;
        end
        else
        begin
            dividend = ({9'd0, v} * INCH_TO_MM_MUL) + INCH_TO_MM_ADD;
        end
        direct = in_item.unit_inch ? ({3'd0, v} * INCH_STEP) : {3'd0, v};
    end

    assign product = PRODUCT_W'(a_dividend_reg) *
                     PRODUCT_W'(a_sel635_reg ? RECIP_635 : RECIP_100);

    always_comb
    begin
        divisor        = b_sel635_reg ? DIV_635 : DIV_100;
        divisor_x2     = {divisor, 1'b0};
        quot_times_div = 31'(b_quot_reg) * 31'(divisor);
        remainder      = b_dividend_reg - quot_times_div[DIVIDEND_W-1:0];
        quot           = (remainder >= DIVIDEND_W'(divisor)) ? (b_quot_reg + 21'd1) : b_quot_reg;
        if (!b_use_div_reg)
        begin
            mag = b_direct_reg;
        end
        else if (b_sel635_reg)
        begin
            mag = {2'd0, quot} * INCH_STEP;
        end
        else
        begin
            mag = {2'd0, quot};
        end
        mag_ext = {1'b0, mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_dividend_reg <= dividend;
            a_sel635_reg   <= sel635;
            a_use_div_reg  <= use_div;
            a_direct_reg   <= direct;
            a_neg_reg      <= v_full[20];
            a_decimals_reg <= in_item.unit_inch ? DECIMALS_INCH : DECIMALS_MM;
        end
        if (en_b && a_valid_reg)
        begin
            b_quot_reg     <= product[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
            b_dividend_reg <= a_dividend_reg;
            b_sel635_reg   <= a_sel635_reg;
            b_use_div_reg  <= a_use_div_reg;
            b_direct_reg   <= a_direct_reg;
            b_neg_reg      <= a_neg_reg;
            b_decimals_reg <= a_decimals_reg;
        end
        if (en_c && b_valid_reg)
        begin
            reading_reg  <= b_neg_reg ? $signed(24'd0 - mag_ext) : $signed(mag_ext);
            decimals_reg <= b_decimals_reg;
        end
    end

    `CFD_ASSERT_IMPL(a_remainder_range, clk, rst_n, b_valid_reg && b_use_div_reg, remainder < DIVIDEND_W'(divisor_x2))
    `CFD_ASSERT_IMPL(a_decimals_code, clk, rst_n, out_valid, (decimals == DECIMALS_MM) || (decimals == DECIMALS_INCH))
    `CFD_ASSERT_IMPL(a_reading_range, clk, rst_n, out_valid, (reading <= READING_LIMIT) && (reading >= -READING_LIMIT))

endmodule

// ===== hdl/caliper_frame_decoder_unit.sv =====
// Caliper serial frame decoder. Each input transaction is one sample of the
// caliper clock and data lines with the 10 ms ticks since the previous sample;
// s_tdata holds clock_level in bit 0, data_level in bit 1 and elapsed_ticks in
// bits 9:2. A transaction is taken every cycle unless m_tready holds it back.
// The unit conversion is a three stage pipeline with one reciprocal
// multiplier. A registered reading leaves on m_tdata (reading in bits 23:0,
// decimals in bits 26:24) for the sample that completes a changed frame, or
// the first frame after reset. Unchanged frames produce nothing.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while no sample is in flight, as the block does not enforce it.
module caliper_frame_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // clock_level, data_level, elapsed_ticks
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // reading, decimals
);
    import cfd_pkg::*;

    cfg_t               cfg_reg;
    logic               frm_valid;
    logic               frm_ready;
    frame_item_t        frm_item;
    logic signed [23:0] reading;
    logic [2:0]         decimals;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROTOCOL_MODE:      cfg_reg.protocol_mode      <= cfg_wdata;
                REG_CLOCK_ACTIVE_LEVEL: cfg_reg.clock_active_level <= cfg_wdata;
                REG_DATA_INVERT:        cfg_reg.data_invert        <= cfg_wdata;
                REG_UNIT_INCH:          cfg_reg.unit_inch          <= cfg_wdata;
            endcase
        end
    end

    cfd_frame u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm_item  (frm_item)
    );

    cfd_convert u_convert
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frm_valid),
        .in_ready  (frm_ready),
        .in_item   (frm_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .reading   (reading),
        .decimals  (decimals)
    );

    assign m_tdata = {5'd0, decimals, reading};

endmodule
